// File: sv/fourier_torsion_derivative_assert.svh
// Assertion macros shared by the torsion derivative modules
`ifndef FOURIER_TORSION_DERIVATIVE_ASSERT_SVH
`define FOURIER_TORSION_DERIVATIVE_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define FTD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define FTD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ftd_pkg.sv
// Package: payload types, constants and the CORDIC arctangent table
package ftd_pkg;

    typedef struct packed {
        logic [15:0]        angle;
        logic [15:0]        phase;
        logic signed [31:0] amplitude;
        logic [3:0]         multiplicity;
        logic               last_term;
        logic               last_coord;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] value;
        logic [15:0]        coord_index;
        logic               last;
    } out_item_t;

    // transaction handed from front to back part
    typedef struct packed {
        logic signed [31:0] cs;
        logic signed [31:0] sn;
        logic signed [31:0] amplitude;
        logic [3:0]         multiplicity;
        logic               last_term;
        logic               last_coord;
    } work_t;

    typedef enum logic [1:0] {
        ORD_ENERGY = 2'd0,
        ORD_GRAD   = 2'd1,
        ORD_HESS   = 2'd2,
        ORD_HESS3  = 2'd3
    } order_t;

    localparam logic signed [31:0] GAIN_INV = 32'sh26DD3B6A;
    localparam logic signed [31:0] ONE_Q30  = 32'sh40000000;
    localparam logic signed [47:0] SUM_MAX  = 48'sh7FFFFFFFFFFF;
    localparam logic signed [47:0] SUM_MIN  = 48'sh800000000000;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: sv/ftd_front.sv
// Front part: argument forming and iterative CORDIC, one step per cycle
module ftd_front #(
    parameter int ANGLE_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ftd_pkg::in_item_t in_item,
    input  logic             in_valid,
    output logic             in_stall,
    output ftd_pkg::work_t   wk,
    output logic             wk_valid,
    input  logic             wk_full
);
    localparam int NSTEP = (ANGLE_BITS < 24) ? ANGLE_BITS : 24;
    localparam logic [4:0] LAST_STEP = 5'(NSTEP - 1);
    localparam logic [31:0] KEEP = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [4:0]         step_reg, step_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next;
    logic signed [32:0] z_reg, z_next;
    logic [1:0]         q_reg, q_next;
    ftd_pkg::in_item_t  it_reg, it_next;

    logic [15:0]        arg;
    logic [31:0]        theta, r;
    logic [1:0]         q;
    logic signed [33:0] xs, ys, cs0, sn0, cs1, sn1;
    logic signed [33:0] lim;
    logic               take;

    assign in_stall = busy_reg || done_reg;
    assign take     = in_valid && !in_stall;
    assign lim      = 34'(ftd_pkg::ONE_Q30);

    // fold the argument into a quadrant and a residual angle
    always_comb
    begin
        arg   = 16'(20'(in_item.multiplicity) * 20'(in_item.angle)) - in_item.phase;
        theta = {arg, 16'h0} & KEEP;
        q     = 2'((theta + 32'h20000000) >> 30);
        r     = theta - {q, 30'h0};
    end

    always_comb
    begin
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        unique case (q_reg)
            2'd0: begin cs0 = x_reg;  sn0 = y_reg;  end
            2'd1: begin cs0 = -y_reg; sn0 = x_reg;  end
            2'd2: begin cs0 = -x_reg; sn0 = -y_reg; end
            default: begin cs0 = y_reg; sn0 = -x_reg; end
        endcase
        cs1 = (cs0 > lim) ? lim : ((cs0 < -lim) ? -lim : cs0);
        sn1 = (sn0 > lim) ? lim : ((sn0 < -lim) ? -lim : sn0);
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        q_next    = q_reg;
        it_next   = it_reg;
        if (take)
        begin
            busy_next = 1'b1;
            step_next = 5'd0;
            x_next    = 34'(ftd_pkg::GAIN_INV);
            y_next    = '0;
            z_next    = 33'($signed(r));
            q_next    = q;
            it_next   = in_item;
        end
        else if (busy_reg)
        begin
            if (!z_reg[32])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - $signed({1'b0, ftd_pkg::atan_turn(step_reg)});
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + $signed({1'b0, ftd_pkg::atan_turn(step_reg)});
            end
            step_next = step_reg + 5'd1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (done_reg && !wk_full)
            done_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        q_reg    <= q_next;
        it_reg   <= it_next;
    end

    assign wk_valid        = done_reg && !wk_full;
    assign wk.cs           = 32'(cs1);
    assign wk.sn           = 32'(sn1);
    assign wk.amplitude    = it_reg.amplitude;
    assign wk.multiplicity = it_reg.multiplicity;
    assign wk.last_term    = it_reg.last_term;
    assign wk.last_coord   = it_reg.last_coord;

    `include "fourier_torsion_derivative_assert.svh"
    `FTD_ASSERT_IMP(a_not_both, clk, rst_n, 1'b1, !(busy_reg && done_reg), "busy and done")
    `FTD_ASSERT_NXT(a_take_busy, clk, rst_n, take, busy_reg, "accept did not start")
    `FTD_ASSERT_IMP(a_step_rng, clk, rst_n, busy_reg, step_reg <= LAST_STEP, "step overrun")
endmodule

// File: sv/ftd_queue.sv
// Two-entry queue between front and back parts
module ftd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  ftd_pkg::work_t wr_data,
    input  logic           wr_en,
    output logic           full,
    output ftd_pkg::work_t rd_data,
    output logic           rd_valid,
    input  logic           rd_en
);
    ftd_pkg::work_t mem_reg [2];
    logic           wp_reg, rp_reg;
    logic [1:0]     cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= ~wp_reg;
            if (rd_en)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

    `include "fourier_torsion_derivative_assert.svh"
    `FTD_ASSERT_IMP(a_no_ovf, clk, rst_n, wr_en, !full, "queue overflow")
    `FTD_ASSERT_IMP(a_no_udf, clk, rst_n, rd_en, rd_valid, "queue underflow")
    `FTD_ASSERT_IMP(a_cnt, clk, rst_n, 1'b1, cnt_reg <= 2'd2, "count range")
endmodule

// File: sv/ftd_back.sv
// Back part: product, term scaling, saturating sum and result register
module ftd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        order,
    input  ftd_pkg::work_t    wk,
    input  logic              wk_valid,
    output logic              wk_take,
    output ftd_pkg::out_item_t res,
    output logic              res_valid,
    input  logic              res_stall
);
    // phase 0 idle, 1 product registered, 2 term registered
    logic               p1_reg, p2_reg;
    logic signed [63:0] prod_reg;
    ftd_pkg::work_t     w_reg;
    logic signed [49:0] term_reg;
    logic signed [47:0] sum_reg;
    logic [15:0]        cnt_reg;
    logic               ov_reg;
    ftd_pkg::out_item_t out_reg;

    logic               hess;
    logic               emit;
    logic signed [31:0] trig;
    logic signed [33:0] p;
    logic [7:0]         nn;
    logic signed [49:0] term_c;
    logic signed [49:0] s;
    logic signed [47:0] sum_n;

    assign hess     = (order == ftd_pkg::ORD_HESS) || (order == ftd_pkg::ORD_HESS3);
    assign wk_take  = wk_valid && !p1_reg && !p2_reg && !(ov_reg && res_stall);
    assign trig     = (order == ftd_pkg::ORD_GRAD) ? wk.sn : wk.cs;

    // energy closes only on the last coordinate, derivatives on every last term
    assign emit = p2_reg && w_reg.last_term &&
                  ((order != ftd_pkg::ORD_ENERGY) || w_reg.last_coord);

    always_comb
    begin
        p  = 34'((prod_reg + 64'sd536870912) >>> 30);
        nn = hess ? 8'(w_reg.multiplicity) * 8'(w_reg.multiplicity)
                  : 8'(w_reg.multiplicity);
        if (order == ftd_pkg::ORD_ENERGY)
            term_c = (w_reg.multiplicity == 4'd0) ? 50'(w_reg.amplitude)
                     : 50'(w_reg.amplitude) + 50'(p);
        else
            term_c = -(50'(p) * $signed({1'b0, 8'(nn)}));
        s     = 50'(sum_reg) + term_reg;
        sum_n = (s > 50'(ftd_pkg::SUM_MAX)) ? ftd_pkg::SUM_MAX
              : ((s < 50'(ftd_pkg::SUM_MIN)) ? ftd_pkg::SUM_MIN : 48'(s));
    end

    always_ff @(posedge clk)
    begin
        if (wk_take)
        begin
            prod_reg <= 64'(wk.amplitude) * 64'(trig);
            w_reg    <= wk;
        end
        if (p1_reg)
            term_reg <= term_c;
    end

    // accumulate and emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg  <= 1'b0;
            p2_reg  <= 1'b0;
            sum_reg <= '0;
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            p1_reg <= wk_take;
            p2_reg <= p1_reg;
            if (emit)
                ov_reg <= 1'b1;
            else if (ov_reg && !res_stall)
                ov_reg <= 1'b0;
            if (p2_reg)
            begin
                if (emit)
                begin
                    out_reg <= '{value: sum_n,
                                 coord_index: (order == ftd_pkg::ORD_ENERGY) ? 16'd0 : cnt_reg,
                                 last: w_reg.last_coord};
                    sum_reg <= '0;
                    cnt_reg <= w_reg.last_coord ? 16'd0 : cnt_reg + 16'd1;
                end
                else
                begin
                    sum_reg <= sum_n;
                    if (w_reg.last_term)
                        cnt_reg <= cnt_reg + 16'd1;
                end
            end
        end
    end

    assign res       = out_reg;
    assign res_valid = ov_reg;

    `include "fourier_torsion_derivative_assert.svh"
    `FTD_ASSERT_IMP(a_one_phase, clk, rst_n, 1'b1, !(p1_reg && p2_reg), "overlap")
    `FTD_ASSERT_NXT(a_hold, clk, rst_n, ov_reg && res_stall, ov_reg && $stable(out_reg),
                    "result lost")
    `FTD_ASSERT_IMP(a_emit_free, clk, rst_n, emit, !ov_reg, "result overwritten")
endmodule

// File: sv/fourier_torsion_derivative.sv
// Top level: Fourier torsion energy, gradient and Hessian-diagonal unit
// The front holds one term at a time and runs one CORDIC rotation per cycle
// (ANGLE_BITS steps, capped at 24), so a new term is accepted only after the
// previous one has been handed to the queue; the back registers the product,
// then the scaled term, then the sum, while the front already works on the next
// term. Output stalls fill the two-entry queue and then hold the input. The
// order set through cfg_data: 0 energy, 1 gradient, 2 or 3 Hessian diagonal.
// Sums saturate to 48 bits.
module fourier_torsion_derivative #(
    parameter int ANGLE_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ftd_pkg::in_item_t  in_data,
    input  logic               in_valid,
    output logic               in_stall,
    output ftd_pkg::out_item_t out_data,
    output logic               out_valid,
    input  logic               out_stall,
    input  logic [1:0]         cfg_data,
    input  logic               cfg_valid,
    output logic               cfg_ready
);
    logic [1:0]     order_reg;
    ftd_pkg::work_t f_wk, q_wk;
    logic           f_valid, q_full, q_valid, q_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= 2'd0;
        else if (cfg_valid && cfg_ready)
            order_reg <= cfg_data;
    end

    ftd_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_item(in_data), .in_valid(in_valid),
        .in_stall(in_stall), .wk(f_wk), .wk_valid(f_valid), .wk_full(q_full)
    );

    ftd_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_data(f_wk), .wr_en(f_valid), .full(q_full),
        .rd_data(q_wk), .rd_valid(q_valid), .rd_en(q_take)
    );

    ftd_back u_back (
        .clk(clk), .rst_n(rst_n), .order(order_reg), .wk(q_wk), .wk_valid(q_valid),
        .wk_take(q_take), .res(out_data), .res_valid(out_valid), .res_stall(out_stall)
    );
endmodule

// File: tb/fourier_torsion_derivative_tb.sv
// Testbench for the Fourier torsion energy, gradient and Hessian-diagonal unit
module fourier_torsion_derivative_tb;

    logic               clk;
    logic               rst_n;
    ftd_pkg::in_item_t  in_data;
    logic               in_valid;
    logic               in_stall;
    ftd_pkg::out_item_t out_data;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         cfg_data;
    logic               cfg_valid;
    logic               cfg_ready;

    // predictor state
    ftd_pkg::order_t    pred_order;
    logic signed [47:0] pred_sum;
    logic [15:0]        pred_coord;

    ftd_pkg::out_item_t sums_due[$];
    int                 errors;

    fourier_torsion_derivative u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // floor shift right on a 64-bit signed value
    function automatic logic signed [63:0] floor_shr(input logic signed [63:0] v, input int s);
        return v >>> s;
    endfunction

    // rotation CORDIC: cosine and sine in Q1.30 of a 32-bit turn phase
    task automatic rotate_turn(input logic [31:0] theta, output logic signed [63:0] cs,
                               output logic signed [63:0] sn);
        logic [31:0]        quad;
        logic [31:0]        rem;
        logic signed [63:0] z, x, y, nx, ny;
        begin
            quad = (theta + 32'h20000000) >> 30;
            rem  = theta - quad * 32'h40000000;
            z = rem[31] ? ($signed({32'd0, rem}) - 64'sh100000000) : $signed({32'd0, rem});
            x = 64'sh26DD3B6A;
            y = 64'sd0;
            for (int i = 0; i < 16; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - floor_shr(y, i);
                    ny = y + floor_shr(x, i);
                    z  = z - $signed({32'd0, ftd_pkg::atan_turn(i[4:0])});
                end
                else
                begin
                    nx = x + floor_shr(y, i);
                    ny = y - floor_shr(x, i);
                    z  = z + $signed({32'd0, ftd_pkg::atan_turn(i[4:0])});
                end
                x = nx;
                y = ny;
            end
            case (quad[1:0])
                2'd0: begin cs = x;  sn = y;  end
                2'd1: begin cs = -y; sn = x;  end
                2'd2: begin cs = -x; sn = -y; end
                default: begin cs = y; sn = -x; end
            endcase
            if (cs > 64'sh40000000) cs = 64'sh40000000;
            if (cs < -64'sh40000000) cs = -64'sh40000000;
            if (sn > 64'sh40000000) sn = 64'sh40000000;
            if (sn < -64'sh40000000) sn = -64'sh40000000;
        end
    endtask

    // work out the sum update and any result for one accepted term
    task automatic predict_term(input ftd_pkg::in_item_t t);
        logic [15:0]        arg;
        logic signed [63:0] cs, sn, amp, p, term, total, n;
        ftd_pkg::out_item_t r;
        begin
            arg = t.multiplicity * t.angle - t.phase;
            rotate_turn({arg, 16'd0}, cs, sn);
            amp = 64'(t.amplitude);
            n   = 64'(t.multiplicity);
            if (pred_order == ftd_pkg::ORD_ENERGY)
            begin
                p = floor_shr(amp * cs + (64'sd1 <<< 29), 30);
                term = (n == 0) ? amp : amp + p;
            end
            else if (pred_order == ftd_pkg::ORD_GRAD)
            begin
                p = floor_shr(amp * sn + (64'sd1 <<< 29), 30);
                term = -(n * p);
            end
            else
            begin
                p = floor_shr(amp * cs + (64'sd1 <<< 29), 30);
                term = -(n * n * p);
            end
            total = pred_sum + term;
            if (total > 64'sh7FFFFFFFFFFF) total = 64'sh7FFFFFFFFFFF;
            if (total < -64'sh800000000000) total = -64'sh800000000000;
            pred_sum = total[47:0];
            if (t.last_term)
            begin
                if (pred_order == ftd_pkg::ORD_ENERGY)
                begin
                    if (!t.last_coord)
                        pred_coord = pred_coord + 16'd1;
                    else
                    begin
                        r.value = pred_sum;
                        r.coord_index = '0;
                        r.last = 1'b1;
                        sums_due.push_back(r);
                        pred_sum = '0;
                        pred_coord = '0;
                    end
                end
                else
                begin
                    r.value = pred_sum;
                    r.coord_index = pred_coord;
                    r.last = t.last_coord;
                    sums_due.push_back(r);
                    pred_sum = '0;
                    pred_coord = t.last_coord ? 16'd0 : pred_coord + 16'd1;
                end
            end
        end
    endtask

    // send one term, then gap at random between bursts
    int burst_left;
    task automatic send_term(input ftd_pkg::in_item_t t);
        begin
            in_data  <= t;
            in_valid <= 1'b1;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            predict_term(t);
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(0, 20);
            end
            else
                burst_left--;
        end
    endtask

    // wait for all results, then let the pipeline drain before a write
    task automatic drain;
        int guard;
        begin
            in_valid <= 1'b0;
            guard = 0;
            while (sums_due.size() != 0 && guard < 200000)
            begin
                @(posedge clk);
                guard++;
            end
            repeat (40) @(posedge clk);
        end
    endtask

    task automatic write_order(input ftd_pkg::order_t o);
        begin
            drain();
            cfg_data  <= o;
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
            pred_order = o;
        end
    endtask

    function automatic ftd_pkg::in_item_t rand_term(input bit tame);
        ftd_pkg::in_item_t t;
        t.angle        = 16'($urandom);
        t.phase        = 16'($urandom);
        t.amplitude    = tame ? $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000
                              : $urandom;
        t.multiplicity = 4'($urandom_range(0, 15));
        t.last_term    = ($urandom_range(0, 3) == 0);
        t.last_coord   = ($urandom_range(0, 2) == 0);
        return t;
    endfunction

    function automatic ftd_pkg::in_item_t make_term(input logic [15:0] a,
                                                    input logic [15:0] ph,
                                                    input logic signed [31:0] v,
                                                    input logic [3:0] n,
                                                    input bit lt, input bit lc);
        ftd_pkg::in_item_t t;
        t.angle = a; t.phase = ph; t.amplitude = v; t.multiplicity = n;
        t.last_term = lt; t.last_coord = lc;
        return t;
    endfunction

    // field extremes and multiplicity zero, in every order
    task automatic test_extremes;
        begin
            for (int o = 0; o < 4; o++)
            begin
                write_order(ftd_pkg::order_t'(o));
                send_term(make_term(16'h0000, 16'h0000, 32'sh7FFFFFFF, 4'd15, 0, 0));
                send_term(make_term(16'hFFFF, 16'hFFFF, 32'sh80000000, 4'd0, 1, 0));
                send_term(make_term(16'h4000, 16'hC000, 32'sh00010000, 4'd1, 0, 1));
                send_term(make_term(16'h8000, 16'h1234, -32'sh00010000, 4'd7, 1, 1));
            end
        end
    endtask

    // saturation at both ends: large Hessian terms, one set of each sign
    task automatic test_saturation;
        begin
            write_order(ftd_pkg::ORD_HESS);
            for (int i = 0; i < 320; i++)
                send_term(make_term(16'h0000, 16'h0000, 32'sh80000000, 4'd15, 0, 0));
            send_term(make_term(16'h0000, 16'h0000, 32'sh80000000, 4'd15, 1, 1));
            for (int i = 0; i < 320; i++)
                send_term(make_term(16'h0000, 16'h0000, 32'sh7FFFFFFF, 4'd15, 0, 0));
            send_term(make_term(16'h0000, 16'h0000, 32'sh7FFFFFFF, 4'd15, 1, 1));
        end
    endtask

    // order change inside a set keeps the running sum
    task automatic test_mode_change;
        begin
            write_order(ftd_pkg::ORD_GRAD);
            send_term(make_term(16'h1000, 16'h0200, 32'sh00030000, 4'd3, 0, 0));
            write_order(ftd_pkg::ORD_ENERGY);
            send_term(make_term(16'h2000, 16'h0100, 32'sh00050000, 4'd2, 1, 0));
            write_order(ftd_pkg::ORD_HESS3);
            send_term(make_term(16'h3000, 16'h0400, 32'sh00020000, 4'd4, 1, 1));
        end
    endtask

    // coordinates counted in energy order carry into gradient indices
    task automatic test_counter_carry;
        begin
            write_order(ftd_pkg::ORD_ENERGY);
            for (int i = 0; i < 20; i++)
                send_term(make_term(16'($urandom), 16'($urandom), $urandom,
                                    4'($urandom), 1, 0));
            write_order(ftd_pkg::ORD_GRAD);
            for (int i = 0; i < 3; i++)
                send_term(make_term(16'($urandom), 16'($urandom), $urandom,
                                    4'($urandom), 1, 0));
            send_term(make_term(16'h0, 16'h0, 32'sh1, 4'd1, 1, 1));
        end
    endtask

    // random sets in random orders
    task automatic test_random;
        ftd_pkg::in_item_t t;
        begin
            for (int phase_no = 0; phase_no < 6; phase_no++)
            begin
                write_order(ftd_pkg::order_t'($urandom_range(0, 3)));
                for (int i = 0; i < 134; i++)
                begin
                    t = rand_term($urandom_range(0, 3) != 0);
                    send_term(t);
                    if (i == 60)
                        drain();
                end
                send_term(make_term(16'($urandom), 16'($urandom), $urandom,
                                    4'($urandom), 1, 1));
            end
        end
    endtask

    // receiver stall pattern, with quiet stretches
    int stall_mode;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode <= 0;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        ftd_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (sums_due.size() == 0)
            begin
                $display("%0t: unexpected result value=%0d coord=%0d last=%0b", $time,
                         out_data.value, out_data.coord_index, out_data.last);
                errors++;
            end
            else
            begin
                want = sums_due.pop_front();
                if (out_data.value !== want.value)
                begin
                    $display("%0t: value expected %0d actual %0d", $time, want.value,
                             out_data.value);
                    errors++;
                end
                if (out_data.coord_index !== want.coord_index)
                begin
                    $display("%0t: coord_index expected %0d actual %0d", $time,
                             want.coord_index, out_data.coord_index);
                    errors++;
                end
                if (out_data.last !== want.last)
                begin
                    $display("%0t: last expected %0b actual %0b", $time, want.last,
                             out_data.last);
                    errors++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #20000000;
        $display("fourier_torsion_derivative verification failed");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        in_data    = '0;
        in_valid   = 1'b0;
        cfg_data   = '0;
        cfg_valid  = 1'b0;
        errors     = 0;
        burst_left = 0;
        pred_order = ftd_pkg::ORD_ENERGY;
        pred_sum   = '0;
        pred_coord = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_mode_change();
        test_random();
        test_saturation();
        test_counter_carry();
        write_order(ftd_pkg::ORD_ENERGY);
        drain();

        if (errors == 0 && sums_due.size() == 0)
            $display("fourier_torsion_derivative verification clean");
        else
            $display("fourier_torsion_derivative verification failed");
        $finish;
    end
endmodule

// File: fourier_torsion_derivative.f
+incdir+sv
sv/ftd_pkg.sv
sv/ftd_front.sv
sv/ftd_queue.sv
sv/ftd_back.sv
sv/fourier_torsion_derivative.sv
tb/fourier_torsion_derivative_tb.sv
